FILE: sv/tta_pkg.sv
`default_nettype none
package tta_pkg;

  localparam int unsigned VertexDepth = 4096;
  localparam int unsigned IdxW        = $clog2(VertexDepth);
  localparam int unsigned LimW        = 13;

  // vertex row: position, texture coordinate
  localparam int unsigned AttrW = 32 * 3 + 16 * 2;
  // accumulator row: x, y, z, touched
  localparam int unsigned AccW  = 32 * 3 + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        vtx_sel;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [11:0]        corner_a;
    logic [11:0]        corner_b;
    logic [11:0]        corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               tangent_w;
    logic [1:0]         status;
  } out_item_t;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_RDA,
    S_RDB,
    S_RDC,
    S_DET0,
    S_DET1,
    S_NUM0,
    S_NUM1,
    S_NUM2,
    S_DIV,
    S_DIVW,
    S_ACC_RD,
    S_ACC_WAIT,
    S_ACC_WR,
    S_READ0,
    S_READ1,
    S_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/triangle_tangent_accumulator_unit.sv
// channel | dir | handshake        | payload
// in      | in  | in_valid/stall   | in_item_t: op, indices, position, texcoord
// out     | out | out_valid/stall  | out_item_t: tangent x/y/z/w, status
// cfg     | in  | cfg_valid/ready  | vertices_in_use, 13 bits
// write, op 3 and any out-of-range item go straight to the result; a read
// fetches the accumulator row; a triangle runs the 64-step serial divider
// once per component, skipped when degenerate, then three accumulator updates.
// after reset a clearing pass zeroes all 4096 accumulator rows; no item
// is taken meanwhile. a stalled result holds the block until it is taken.
`default_nettype none
module triangle_tangent_accumulator_unit
  import tta_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [LimW-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [LimW-1:0] lim_q;
  in_item_t item_q, item_d;
  out_item_t res_q, res_d;
  logic [IdxW:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;

  // attribute ram
  logic attr_we;
  logic [IdxW-1:0] attr_wa, attr_ra;
  logic [AttrW-1:0] attr_wd, attr_rd;
  // accumulator ram
  logic acc_we;
  logic [IdxW-1:0] acc_wa, acc_ra;
  logic [AccW-1:0] acc_wd, acc_rd;

  tta_ram #(.Width(AttrW), .Depth(VertexDepth)) u_attr (
    .clk_i, .we_i(attr_we), .waddr_i(attr_wa), .wdata_i(attr_wd),
    .raddr_i(attr_ra), .rdata_o(attr_rd));
  tta_ram #(.Width(AccW), .Depth(VertexDepth)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(acc_wa), .wdata_i(acc_wd),
    .raddr_i(acc_ra), .rdata_o(acc_rd));

  // per-corner data
  logic signed [31:0] px_q [3], py_q [3], pz_q [3], px_d [3], py_d [3], pz_d [3];
  logic signed [15:0] tu_q [3], tv_q [3], tu_d [3], tv_d [3];
  logic signed [63:0] det_q, det_d, num_q [3], num_d [3];
  logic signed [31:0] tan_q [3], tan_d [3];
  logic signed [63:0] m0, m1;
  logic signed [16:0] d1u, d1v, d2u, d2v;
  logic signed [32:0] ea, eb;

  div_ctl_t dctl;
  div_sts_t dsts;
  logic signed [63:0] dquo;

  tta_div u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .num_i(num_q[k_q]), .den_i(det_q),
    .sts_o(dsts), .quo_o(dquo));

  logic [IdxW:0] lim_eff;
  assign lim_eff = (lim_q > LimW'(VertexDepth)) ? (IdxW+1)'(VertexDepth)
                                                : (IdxW+1)'(lim_q);

  logic [IdxW-1:0] corner;
  always_comb begin
    case (k_q)
      2'd0:    corner = item_q.corner_a;
      2'd1:    corner = item_q.corner_b;
      default: corner = item_q.corner_c;
    endcase
  end

  assign d1u = 17'(tu_q[1]) - 17'(tu_q[0]);
  assign d1v = 17'(tv_q[1]) - 17'(tv_q[0]);
  assign d2u = 17'(tu_q[2]) - 17'(tu_q[0]);
  assign d2v = 17'(tv_q[2]) - 17'(tv_q[0]);

  // edge pair for current component
  always_comb begin
    case (k_q)
      2'd0: begin
        ea = 33'(px_q[1]) - 33'(px_q[0]);
        eb = 33'(px_q[2]) - 33'(px_q[0]);
      end
      2'd1: begin
        ea = 33'(py_q[1]) - 33'(py_q[0]);
        eb = 33'(py_q[2]) - 33'(py_q[0]);
      end
      default: begin
        ea = 33'(pz_q[1]) - 33'(pz_q[0]);
        eb = 33'(pz_q[2]) - 33'(pz_q[0]);
      end
    endcase
  end

  logic signed [63:0] sx, sy, sz;
  assign sx = 64'($signed(acc_rd[AccW-1 -: 32])) + 64'(tan_q[0]);
  assign sy = 64'($signed(acc_rd[AccW-33 -: 32])) + 64'(tan_q[1]);
  assign sz = 64'($signed(acc_rd[AccW-65 -: 32])) + 64'(tan_q[2]);

  // sequencer
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    det_d   = det_q;
    for (int i = 0; i < 3; i++) begin
      px_d[i] = px_q[i]; py_d[i] = py_q[i]; pz_d[i] = pz_q[i];
      tu_d[i] = tu_q[i]; tv_d[i] = tv_q[i];
      num_d[i] = num_q[i]; tan_d[i] = tan_q[i];
    end
    m0 = '0;
    m1 = '0;
    attr_we = 1'b0;
    attr_wa = item_q.vtx_sel;
    attr_wd = {item_q.pos_x, item_q.pos_y, item_q.pos_z, item_q.tex_u, item_q.tex_v};
    attr_ra = corner;
    acc_we  = 1'b0;
    acc_wa  = corner;
    acc_wd  = '0;
    acc_ra  = corner;
    dctl.start = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        acc_we = 1'b1;
        acc_wa = cnt_q[IdxW-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == (IdxW+1)'(VertexDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          k_d    = '0;
          state_d = S_OUT;
          case (op_e'(in_data_i.op))
            OP_WRITE: begin
              if ((IdxW+1)'(in_data_i.vtx_sel) >= lim_eff) res_d.status = ST_RANGE;
              else begin
                attr_we = 1'b1;
                attr_wa = in_data_i.vtx_sel;
                attr_wd = {in_data_i.pos_x, in_data_i.pos_y, in_data_i.pos_z,
                           in_data_i.tex_u, in_data_i.tex_v};
                acc_we  = 1'b1;
                acc_wa  = in_data_i.vtx_sel;
              end
            end
            OP_READ: begin
              if ((IdxW+1)'(in_data_i.vtx_sel) >= lim_eff) res_d.status = ST_RANGE;
              else state_d = S_READ0;
            end
            OP_TRI: begin
              if ((IdxW+1)'(in_data_i.corner_a) >= lim_eff ||
                  (IdxW+1)'(in_data_i.corner_b) >= lim_eff ||
                  (IdxW+1)'(in_data_i.corner_c) >= lim_eff) res_d.status = ST_RANGE;
              else state_d = S_RDA;
            end
            default: ;
          endcase
        end
      end
      S_READ0: begin
        acc_ra  = item_q.vtx_sel;
        state_d = S_READ1;
      end
      S_READ1: begin
        res_d.tangent_x = acc_rd[AccW-1 -: 32];
        res_d.tangent_y = acc_rd[AccW-33 -: 32];
        res_d.tangent_z = acc_rd[AccW-65 -: 32];
        res_d.tangent_w = acc_rd[0];
        state_d = S_OUT;
      end
      // three attribute reads, each result lands in the next cycle
      S_RDA, S_RDB, S_RDC: begin
        if (state_q != S_RDA) begin
          px_d[k_q - 2'd1] = attr_rd[AttrW-1 -: 32];
          py_d[k_q - 2'd1] = attr_rd[AttrW-33 -: 32];
          pz_d[k_q - 2'd1] = attr_rd[AttrW-65 -: 32];
          tu_d[k_q - 2'd1] = attr_rd[31:16];
          tv_d[k_q - 2'd1] = attr_rd[15:0];
        end
        k_d = k_q + 2'd1;
        state_d = (state_q == S_RDA) ? S_RDB : (state_q == S_RDB) ? S_RDC : S_DET0;
      end
      S_DET0: begin
        px_d[2] = attr_rd[AttrW-1 -: 32];
        py_d[2] = attr_rd[AttrW-33 -: 32];
        pz_d[2] = attr_rd[AttrW-65 -: 32];
        tu_d[2] = attr_rd[31:16];
        tv_d[2] = attr_rd[15:0];
        state_d = S_DET1;
      end
      S_DET1: begin
        m0 = 64'(d1u) * 64'(d2v);
        m1 = 64'(d2u) * 64'(d1v);
        det_d = m0 - m1;
        k_d = '0;
        state_d = S_NUM0;
      end
      S_NUM0: begin
        if (det_q == '0) begin
          res_d.status = ST_DEGEN;
          k_d = '0;
          state_d = S_ACC_RD;
        end else state_d = S_NUM1;
      end
      // numerator per component, scaled by 4096
      S_NUM1: begin
        m0 = 64'(d2v) * 64'(ea);
        m1 = 64'(d1v) * 64'(eb);
        num_d[k_q] = (m0 - m1) <<< 12;
        if (k_q == 2'd2) begin
          k_d = '0;
          state_d = S_DIV;
        end else k_d = k_q + 2'd1;
      end
      S_DIV: begin
        dctl.start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (dsts.done) begin
          tan_d[k_q] = sat32(dquo);
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_ACC_RD;
          end else begin
            k_d = k_q + 2'd1;
            state_d = S_DIV;
          end
        end
      end
      S_ACC_RD: state_d = S_ACC_WAIT;
      S_ACC_WAIT: state_d = S_ACC_WR;
      // read-modify-write one corner
      S_ACC_WR: begin
        acc_we = 1'b1;
        if (res_q.status == ST_DEGEN) acc_wd = {acc_rd[AccW-1:1], 1'b1};
        else acc_wd = {sat32(sx), sat32(sy), sat32(sz), 1'b1};
        if (k_q == 2'd2) state_d = S_OUT;
        else begin
          k_d = k_q + 2'd1;
          state_d = S_ACC_RD;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      k_q     <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (cfg_valid_i) lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    det_q  <= det_d;
    for (int i = 0; i < 3; i++) begin
      px_q[i] <= px_d[i]; py_q[i] <= py_d[i]; pz_q[i] <= pz_d[i];
      tu_q[i] <= tu_d[i]; tv_q[i] <= tv_d[i];
      num_q[i] <= num_d[i]; tan_q[i] <= tan_d[i];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

FILE: sv/tta_ram.sv
`default_nettype none
module tta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/tta_div.sv
`default_nettype none
module tta_div
  import tta_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire div_ctl_t           ctl_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [63:0] den_i,
  output div_sts_t                sts_o,
  output logic signed [63:0]      quo_o
);

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shifted = {rem_q[62:0], quo_q[63]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = num_i[63] ? 64'(-num_i) : num_i;
      den_d  = den_i[63] ? 64'(-den_i) : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = neg_q ? 64'(-quo_q) : quo_q;

endmodule
`default_nettype wire

FILE: sv/tta_checker.sv
`default_nettype none
module tta_checker
  import tta_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // status code is never the unused value
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_RANGE) else $error("bad status");

  // no item taken while a result is shown
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");

  // failed results carry a clear touched flag
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.tangent_w == 1'b0)
    else $error("flag on failed item");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");

endmodule

bind triangle_tangent_accumulator_unit tta_checker u_tta_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o);
`default_nettype wire

FILE: sim/tb_triangle_tangent_accumulator_unit.sv
`default_nettype none
module tb_triangle_tangent_accumulator_unit;
  import tta_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 150;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [LimW-1:0] cfg_data_i;

  triangle_tangent_accumulator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the vertex store
  int      shadow_px [VertexDepth];
  int      shadow_py [VertexDepth];
  int      shadow_pz [VertexDepth];
  shortint shadow_tu [VertexDepth];
  shortint shadow_tv [VertexDepth];
  int      shadow_ax [VertexDepth];
  int      shadow_ay [VertexDepth];
  int      shadow_az [VertexDepth];
  bit      shadow_touched [VertexDepth];
  bit      vertex_written [VertexDepth];
  int      written_list[$];
  int unsigned vertex_limit;

  out_item_t expected_results[$];
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;

  always #10 clk_i = ~clk_i;

  function automatic int clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return int'(v[31:0]);
  endfunction

  // one tangent component: (d2v*ea - d1v*eb) * 4096 / det, toward zero
  function automatic int tangent_part(longint ea, longint eb, longint d1v, longint d2v,
                                      longint det);
    logic signed [127:0] num;
    logic signed [127:0] den;
    num = d2v * ea - d1v * eb;
    den = det;
    return clamp32((num * 128'sd4096) / den);
  endfunction

  function automatic void add_tangent(int i, int tx, int ty, int tz);
    shadow_ax[i] = clamp32(longint'(shadow_ax[i]) + tx);
    shadow_ay[i] = clamp32(longint'(shadow_ay[i]) + ty);
    shadow_az[i] = clamp32(longint'(shadow_az[i]) + tz);
  endfunction

  // apply one accepted beat to the shadow store and return its result
  function automatic out_item_t tangent_step(in_item_t it);
    out_item_t r;
    int a, b, c, vi;
    longint d1u, d1v, d2u, d2v, det;
    int tx, ty, tz;
    r = '0;
    vi = int'(it.vtx_sel);
    a = int'(it.corner_a);
    b = int'(it.corner_b);
    c = int'(it.corner_c);
    case (op_e'(it.op))
      OP_WRITE: begin
        if (vi < vertex_limit) begin
          shadow_px[vi] = it.pos_x;
          shadow_py[vi] = it.pos_y;
          shadow_pz[vi] = it.pos_z;
          shadow_tu[vi] = it.tex_u;
          shadow_tv[vi] = it.tex_v;
          shadow_ax[vi] = 0;
          shadow_ay[vi] = 0;
          shadow_az[vi] = 0;
          shadow_touched[vi] = 0;
          if (!vertex_written[vi]) written_list.push_back(vi);
          vertex_written[vi] = 1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_TRI: begin
        if (a >= vertex_limit || b >= vertex_limit || c >= vertex_limit) begin
          r.status = ST_RANGE;
        end else begin
          d1u = longint'(shadow_tu[b]) - shadow_tu[a];
          d1v = longint'(shadow_tv[b]) - shadow_tv[a];
          d2u = longint'(shadow_tu[c]) - shadow_tu[a];
          d2v = longint'(shadow_tv[c]) - shadow_tv[a];
          det = d1u * d2v - d2u * d1v;
          if (det == 0) begin
            r.status = ST_DEGEN;
          end else begin
            tx = tangent_part(longint'(shadow_px[b]) - shadow_px[a],
                              longint'(shadow_px[c]) - shadow_px[a], d1v, d2v, det);
            ty = tangent_part(longint'(shadow_py[b]) - shadow_py[a],
                              longint'(shadow_py[c]) - shadow_py[a], d1v, d2v, det);
            tz = tangent_part(longint'(shadow_pz[b]) - shadow_pz[a],
                              longint'(shadow_pz[c]) - shadow_pz[a], d1v, d2v, det);
            add_tangent(a, tx, ty, tz);
            add_tangent(b, tx, ty, tz);
            add_tangent(c, tx, ty, tz);
          end
          shadow_touched[a] = 1;
          shadow_touched[b] = 1;
          shadow_touched[c] = 1;
        end
      end
      OP_READ: begin
        if (vi < vertex_limit) begin
          r.tangent_x = shadow_ax[vi];
          r.tangent_y = shadow_ay[vi];
          r.tangent_z = shadow_az[vi];
          r.tangent_w = shadow_touched[vi];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %h", out_data_o);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.tangent_x !== want.tangent_x || out_data_o.tangent_y !== want.tangent_y
            || out_data_o.tangent_z !== want.tangent_z
            || out_data_o.tangent_w !== want.tangent_w || out_data_o.status !== want.status)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("exp x=%h y=%h z=%h w=%b st=%0d, got x=%h y=%h z=%h w=%b st=%0d",
                     want.tangent_x, want.tangent_y, want.tangent_z, want.tangent_w,
                     want.status, out_data_o.tangent_x, out_data_o.tangent_y,
                     out_data_o.tangent_z, out_data_o.tangent_w, out_data_o.status);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("triangle_tangent_accumulator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    expected_results.push_back(tangent_step(it));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_vertex_limit(int unsigned value);
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[LimW-1:0];
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    vertex_limit = (value[LimW-1:0] < VertexDepth) ? value[LimW-1:0] : VertexDepth;
  endtask

  function automatic in_item_t noise_item();
    logic [191:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t write_item(int idx, int px, int py, int pz,
                                          shortint tu, shortint tv);
    in_item_t it;
    it = noise_item();
    it.op = OP_WRITE;
    it.vtx_sel = 12'(idx);
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.tex_u = tu;
    it.tex_v = tv;
    return it;
  endfunction

  function automatic in_item_t tri_item(int a, int b, int c);
    in_item_t it;
    it = noise_item();
    it.op = OP_TRI;
    it.corner_a = 12'(a);
    it.corner_b = 12'(b);
    it.corner_c = 12'(c);
    return it;
  endfunction

  function automatic in_item_t read_item(int idx);
    in_item_t it;
    it = noise_item();
    it.op = OP_READ;
    it.vtx_sel = 12'(idx);
    return it;
  endfunction

  // a written vertex under the current limit, or -1
  function automatic int pick_written();
    int v;
    for (int k = 0; k < 8; k++) begin
      v = written_list[$urandom_range(0, written_list.size() - 1)];
      if (v < vertex_limit) return v;
    end
    return -1;
  endfunction

  function automatic in_item_t random_item();
    int unsigned roll;
    int a, b, c;
    in_item_t it;
    roll = $urandom_range(0, 99);
    a = (written_list.size() > 0) ? pick_written() : -1;
    b = (written_list.size() > 0) ? pick_written() : -1;
    c = (written_list.size() > 0) ? pick_written() : -1;
    if (roll < 45 && a >= 0 && b >= 0 && c >= 0) begin
      if ($urandom_range(0, 19) == 0) c = a;
      return tri_item(a, b, c);
    end
    if (roll < 65 && vertex_limit > 0) begin
      return read_item($urandom_range(0, vertex_limit - 1));
    end
    if (roll < 95 && vertex_limit > 0) begin
      it = write_item($urandom_range(0, vertex_limit - 1), $urandom, $urandom, $urandom,
                      shortint'($urandom), shortint'($urandom));
      // mostly small geometry so that saturation stays occasional
      if ($urandom_range(0, 1)) begin
        it.pos_x = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        it.pos_y = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        it.pos_z = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      end
      // coarse texture grid gives collinear, degenerate triangles now and then
      if ($urandom_range(0, 3) == 0) begin
        it.tex_u = 16'($urandom_range(0, 3)) <<< 12;
        it.tex_v = 16'($urandom_range(0, 3)) <<< 12;
      end
      return it;
    end
    // noise: unused op, or an index past the limit
    it = noise_item();
    if ($urandom_range(0, 1)) begin
      it.op = OP_NONE;
    end else if (vertex_limit < VertexDepth) begin
      it.op = 2'($urandom_range(0, 2));
      it.vtx_sel = 12'($urandom_range(vertex_limit, VertexDepth - 1));
      it.corner_b = 12'($urandom_range(vertex_limit, VertexDepth - 1));
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  task automatic test_extremes();
    set_vertex_limit(VertexDepth);
    send_item(write_item(0, 32'h80000000, 32'h7fffffff, 0, 16'sh8000, 16'sh7fff));
    send_item(write_item(1, 32'h7fffffff, 32'h80000000, 32'h00010000, 16'sh7fff, 16'sh8000));
    send_item(write_item(4095, 32'h00010000, 32'h00020000, 32'hffff0000, 16'sh1000,
                         16'sh0000));
    send_item(tri_item(0, 1, 4095));
    send_item(read_item(0));
    send_item(read_item(1));
    send_item(read_item(4095));
    // tiny texture determinant drives the tangent into saturation
    send_item(write_item(2, 0, 0, 0, 16'sh0000, 16'sh0000));
    send_item(write_item(3, 32'h7fffffff, 32'h80000000, 32'h40000000, 16'sd1, 16'sd0));
    send_item(write_item(4, 32'h80000000, 32'h7fffffff, 0, 16'sd0, 16'sd1));
    send_item(tri_item(2, 3, 4));
    send_item(tri_item(2, 3, 4));
    send_item(read_item(3));
    // repeated corner and collinear texture coordinates
    send_item(tri_item(2, 2, 3));
    send_item(write_item(5, 32'h00030000, 0, 0, 16'sd2, 16'sd0));
    send_item(tri_item(2, 3, 5));
    send_item(read_item(5));
    send_item(read_item(2000));
    send_item(noise_item() | in_item_t'({2'b11, {($bits(in_item_t) - 2){1'b0}}}));
  endtask

  task automatic test_limits();
    set_vertex_limit(3);
    send_item(write_item(3, 1, 2, 3, 16'sd4, 16'sd5));
    send_item(read_item(4095));
    send_item(tri_item(0, 1, 3));
    send_item(read_item(2));
    set_vertex_limit(0);
    send_item(write_item(0, 1, 2, 3, 16'sd4, 16'sd5));
    send_item(read_item(0));
    set_vertex_limit(8191);
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned limit_value, int unsigned count);
    set_vertex_limit(limit_value);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 400;
    repeat (40) send_item(random_item());
    wait_for_results();
    repeat (10) send_item(random_item());
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    out_stall_i <= 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    vertex_limit = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_limits();
    test_random_phase(0, 0, 8191, 345);
    test_random_phase(51, 0, $urandom_range(3, 64), 345);
    test_random_phase(0, 51, VertexDepth, 345);
    test_random_phase(29, 29, $urandom_range(3, VertexDepth), 345);
    test_backpressure();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("triangle_tangent_accumulator_unit: match");
    end else begin
      $display("triangle_tangent_accumulator_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
